// ===== hw/rtl/oht_pkg.sv =====
// ----------------------------------------------------------------------------
// oht_pkg
// shared constants, operation codes and control structs for the otsu block
// ----------------------------------------------------------------------------
package oht_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int LEVELS         = 256;
    localparam int LEVEL_BITS     = 8;

    // multiplier operations of one sweep step
    localparam logic [2:0] OP_P   = 3'd0;  // sb * n
    localparam logic [2:0] OP_Q   = 3'd1;  // s * wb
    localparam logic [2:0] OP_NUM = 3'd2;  // d * d
    localparam logic [2:0] OP_DEN = 3'd3;  // wb * (n - wb)
    localparam logic [2:0] OP_L   = 3'd4;  // num * best_den
    localparam logic [2:0] OP_R   = 3'd5;  // best_num * den

    typedef struct packed {
        logic       px_read;
        logic       px_update;
        logic       sw_init;
        logic       sw_read;
        logic       sw_acc;
        logic       mul_start;
        logic       mul_store;
        logic       diff;
        logic       cmp;
        logic       t_inc;
        logic       finish;
        logic [2:0] op;
    } oht_cmd_t;

    typedef struct packed {
        logic last;
        logic special;
        logic mul_busy;
        logic t_end;
        logic out_busy;
    } oht_status_t;

endpackage

// ===== hw/rtl/oht_ram.sv =====
// ----------------------------------------------------------------------------
// oht_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module oht_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/oht_ctrl.sv =====
// ----------------------------------------------------------------------------
// oht_ctrl
// sequencer for pixel counting, threshold sweep and result hand-off
// ----------------------------------------------------------------------------
module oht_ctrl import oht_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    input  oht_status_t status,
    output oht_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_UPD    = 4'd1;
    localparam logic [3:0] S_CHK    = 4'd2;
    localparam logic [3:0] S_SW_RD  = 4'd3;
    localparam logic [3:0] S_SW_ACC = 4'd4;
    localparam logic [3:0] S_MSTART = 4'd5;
    localparam logic [3:0] S_MWAIT  = 4'd6;
    localparam logic [3:0] S_DIFF   = 4'd7;
    localparam logic [3:0] S_CMP    = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [2:0] op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_P;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign pixel_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pixel_valid)
                begin
                    cmd.px_read = 1'b1;
                    state_next  = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.px_update = 1'b1;
                state_next    = status.last ? S_CHK : S_IDLE;
            end
            S_CHK:
            begin
                if (status.special)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.sw_init = 1'b1;
                    state_next  = S_SW_RD;
                end
            end
            S_SW_RD:
            begin
                cmd.sw_read = 1'b1;
                state_next  = S_SW_ACC;
            end
            S_SW_ACC:
            begin
                cmd.sw_acc = 1'b1;
                op_next    = OP_P;
                state_next = S_MSTART;
            end
            S_MSTART:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (!status.mul_busy)
                begin
                    cmd.mul_store = 1'b1;
                    case (op_reg)
                        OP_P:
                        begin
                            op_next    = OP_Q;
                            state_next = S_MSTART;
                        end
                        OP_Q:    state_next = S_DIFF;
                        OP_NUM:
                        begin
                            op_next    = OP_DEN;
                            state_next = S_MSTART;
                        end
                        OP_DEN:
                        begin
                            op_next    = OP_L;
                            state_next = S_MSTART;
                        end
                        OP_L:
                        begin
                            op_next    = OP_R;
                            state_next = S_MSTART;
                        end
                        default: state_next = S_CMP;
                    endcase
                end
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                op_next    = OP_NUM;
                state_next = S_MSTART;
            end
            S_CMP:
            begin
                cmd.cmp = 1'b1;
                if (status.t_end)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.t_inc  = 1'b1;
                    state_next = S_SW_RD;
                end
            end
            S_FIN:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/oht_datapath.sv =====
// ----------------------------------------------------------------------------
// oht_datapath
// histogram store, running sums, shift-add multiplier and best-level tracking
// ----------------------------------------------------------------------------
module oht_datapath import oht_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [LEVEL_BITS-1:0] pixel,
    input  logic                  last,
    input  oht_cmd_t              cmd,
    output oht_status_t           status,
    output logic [LEVEL_BITS-1:0] threshold,
    output logic                  threshold_valid,
    input  logic                  threshold_stall
);

    localparam int NW = COUNT_BITS + LEVEL_BITS;
    localparam int SW = COUNT_BITS + 2 * LEVEL_BITS;
    localparam int PW = SW + NW;
    localparam int QW = 2 * PW;
    localparam int EW = 2 * NW;
    localparam int CW = QW + EW;

    logic [LEVEL_BITS-1:0] pix_reg, t_reg, lo_reg, hi_reg, best_t_reg, thr_reg;
    logic                  last_reg, have_reg, out_valid_reg, rd_vld_reg;
    logic [LEVELS-1:0]     vld_reg;
    logic [NW-1:0]         n_reg, wb_reg;
    logic [SW-1:0]         s_reg, sb_reg;
    logic [PW-1:0]         p_reg, q_reg, d_reg;
    logic [QW-1:0]         num_reg, best_num_reg;
    logic [EW-1:0]         den_reg, best_den_reg;
    logic [CW-1:0]         lhs_reg, rhs_reg;
    logic [CW-1:0]         ma_reg, macc_reg, mul_a;
    logic [PW-1:0]         mb_reg, mul_b;
    logic                  mbusy_reg;

    logic [COUNT_BITS-1:0] ram_q, h_cur, h_new;
    logic                  h_sat, ram_re, special;
    logic [LEVEL_BITS-1:0] raddr;
    logic [LEVEL_BITS:0]   lo_plus;

    assign raddr  = cmd.px_read ? pixel : t_reg;
    assign ram_re = cmd.px_read | cmd.sw_read;
    assign h_cur  = rd_vld_reg ? ram_q : '0;
    assign h_sat  = (h_cur == {COUNT_BITS{1'b1}});
    assign h_new  = h_sat ? h_cur : h_cur + 1'b1;

    oht_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (LEVELS)
    ) u_hist (
        .clk   (clk),
        .we    (cmd.px_update),
        .waddr (pix_reg),
        .wdata (h_new),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (ram_q)
    );

    assign lo_plus = {1'b0, lo_reg} + 1'b1;
    assign special = (hi_reg == lo_reg) || ({1'b0, hi_reg} == lo_plus);

    always_comb
    begin
        case (cmd.op)
            OP_P:
            begin
                mul_a = CW'(sb_reg);
                mul_b = PW'(n_reg);
            end
            OP_Q:
            begin
                mul_a = CW'(s_reg);
                mul_b = PW'(wb_reg);
            end
            OP_NUM:
            begin
                mul_a = CW'(d_reg);
                mul_b = d_reg;
            end
            OP_DEN:
            begin
                mul_a = CW'(wb_reg);
                mul_b = PW'(n_reg - wb_reg);
            end
            OP_L:
            begin
                mul_a = CW'(num_reg);
                mul_b = PW'(best_den_reg);
            end
            default:
            begin
                mul_a = CW'(best_num_reg);
                mul_b = PW'(den_reg);
            end
        endcase
    end

    // shift-add multiplier, one multiplier bit per cycle, stops once b runs out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg <= 1'b0;
        end
        else if (cmd.mul_start)
        begin
            mbusy_reg <= 1'b1;
        end
        else if (mbusy_reg && (mb_reg == '0))
        begin
            mbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            ma_reg   <= mul_a;
            mb_reg   <= mul_b;
            macc_reg <= '0;
        end
        else if (mbusy_reg && (mb_reg != '0))
        begin
            if (mb_reg[0])
            begin
                macc_reg <= macc_reg + ma_reg;
            end
            ma_reg <= {ma_reg[CW-2:0], 1'b0};
            mb_reg <= {1'b0, mb_reg[PW-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            lo_reg        <= '1;
            hi_reg        <= '0;
            n_reg         <= '0;
            s_reg         <= '0;
            out_valid_reg <= 1'b0;
            have_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !threshold_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.px_update)
            begin
                vld_reg[pix_reg] <= 1'b1;
                if (pix_reg < lo_reg)
                begin
                    lo_reg <= pix_reg;
                end
                if (pix_reg > hi_reg)
                begin
                    hi_reg <= pix_reg;
                end
                // totals follow the saturated bins
                if (!h_sat)
                begin
                    n_reg <= n_reg + 1'b1;
                    s_reg <= s_reg + SW'(pix_reg);
                end
            end
            if (cmd.sw_init)
            begin
                have_reg <= 1'b0;
            end
            if (cmd.cmp && (!have_reg || (lhs_reg > rhs_reg)))
            begin
                have_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                vld_reg       <= '0;
                lo_reg        <= '1;
                hi_reg        <= '0;
                n_reg         <= '0;
                s_reg         <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.px_read)
        begin
            pix_reg  <= pixel;
            last_reg <= last;
        end
        if (ram_re)
        begin
            rd_vld_reg <= vld_reg[raddr];
        end
        if (cmd.sw_init)
        begin
            t_reg        <= lo_reg;
            wb_reg       <= '0;
            sb_reg       <= '0;
            best_num_reg <= '0;
            best_den_reg <= EW'(1);
        end
        if (cmd.sw_acc)
        begin
            wb_reg <= wb_reg + NW'(h_cur);
            sb_reg <= sb_reg + SW'(h_cur) * SW'(t_reg);
        end
        if (cmd.t_inc)
        begin
            t_reg <= t_reg + 1'b1;
        end
        if (cmd.mul_store)
        begin
            case (cmd.op)
                OP_P:    p_reg   <= macc_reg[PW-1:0];
                OP_Q:    q_reg   <= macc_reg[PW-1:0];
                OP_NUM:  num_reg <= macc_reg[QW-1:0];
                OP_DEN:  den_reg <= macc_reg[EW-1:0];
                OP_L:    lhs_reg <= macc_reg;
                default: rhs_reg <= macc_reg;
            endcase
        end
        if (cmd.diff)
        begin
            d_reg <= (p_reg >= q_reg) ? (p_reg - q_reg) : (q_reg - p_reg);
        end
        if (cmd.cmp && (!have_reg || (lhs_reg > rhs_reg)))
        begin
            best_t_reg   <= t_reg;
            best_num_reg <= num_reg;
            best_den_reg <= den_reg;
        end
        if (cmd.finish)
        begin
            thr_reg <= special ? lo_reg : best_t_reg;
        end
    end

    assign status.last     = last_reg;
    assign status.special  = special;
    assign status.mul_busy = mbusy_reg;
    assign status.t_end    = (t_reg == hi_reg - 1'b1);
    assign status.out_busy = out_valid_reg;

    assign threshold       = thr_reg;
    assign threshold_valid = out_valid_reg;

endmodule

// ===== hw/rtl/otsu_histogram_threshold.sv =====
// each pixel gets a histogram read, then a write back while the input stalls;
// after the last pixel, the sweep runs per level a histogram read, an accumulate,
// six shift-add multiplies on the shared multiplier, a difference and a compare;
// the result then waits in an output register
// reset: asynchronous, active low; histogram bins read as zero through valid bits
// ----------------------------------------------------------------------------
// otsu_histogram_threshold
// builds a grey-level histogram per frame and picks the otsu threshold
// ----------------------------------------------------------------------------
module otsu_histogram_threshold import oht_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [LEVEL_BITS-1:0] pixel,
    input  logic                  last,
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    output logic [LEVEL_BITS-1:0] threshold,
    output logic                  threshold_valid,
    input  logic                  threshold_stall
);

    oht_cmd_t    cmd;
    oht_status_t status;

    oht_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .status      (status),
        .cmd         (cmd)
    );

    oht_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .pixel           (pixel),
        .last            (last),
        .cmd             (cmd),
        .status          (status),
        .threshold       (threshold),
        .threshold_valid (threshold_valid),
        .threshold_stall (threshold_stall)
    );

endmodule

// ===== hw/rtl/oht_checker.sv =====
// ----------------------------------------------------------------------------
// oht_checker
// port-level checks for the otsu block, bound to the top level
// ----------------------------------------------------------------------------
module oht_checker (
    input logic       clk,
    input logic       rst_n,
    input logic [7:0] pixel,
    input logic       last,
    input logic       pixel_valid,
    input logic       pixel_stall,
    input logic [7:0] threshold,
    input logic       threshold_valid,
    input logic       threshold_stall
);

    // a waiting result stays
    assert property (@(posedge clk) disable iff (!rst_n)
        threshold_valid && threshold_stall |=> threshold_valid)
        else $error("threshold dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        threshold_valid && threshold_stall |=> $stable(threshold))
        else $error("threshold changed while stalled");

    // a request is followed by its write-back cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_stall |=> pixel_stall)
        else $error("pixel taken during histogram update");

    // a result only appears out of the busy finish step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(threshold_valid) |-> $past(pixel_stall))
        else $error("result appeared while input was open");

endmodule

bind otsu_histogram_threshold oht_checker u_chk (.*);

// ===== sim/tb_otsu_histogram_threshold.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_otsu_histogram_threshold
// streams pixel frames into the otsu block, predicts each frame threshold
// with exact integer variance comparison and checks every returned result
// ----------------------------------------------------------------------------
module tb_otsu_histogram_threshold;
    import oht_pkg::*;

    localparam int IDLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 3000;

    typedef bit [255:0] wide_t;

    typedef struct {
        bit [7:0] pix;
        bit       lst;
        int       reps;
        bit       typed;
        bit [7:0] thr;
    } pixel_row_t;

    logic                  clk;
    logic                  rst_n;
    logic [LEVEL_BITS-1:0] pixel;
    logic                  last;
    logic                  pixel_valid;
    logic                  pixel_stall;
    logic [LEVEL_BITS-1:0] threshold;
    logic                  threshold_valid;
    logic                  threshold_stall;

    bit [15:0] bin_count [LEVELS];
    bit [15:0] frame_pixels;
    bit [7:0]  threshold_q[$];
    int        fails;
    int        idle_cycles = 0;
    int        burst_left;
    int        pixels_sent;
    int        frames_sent;
    int        results_seen;
    bit        hold_req;
    bit        holding;

    otsu_histogram_threshold i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .pixel           (pixel),
        .last            (last),
        .pixel_valid     (pixel_valid),
        .pixel_stall     (pixel_stall),
        .threshold       (threshold),
        .threshold_valid (threshold_valid),
        .threshold_stall (threshold_stall)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic bit [7:0] otsu_level();
        int    lo;
        int    hi;
        bit    have;
        bit [7:0] best;
        wide_t n, s, wb, sb, p, q, d, num, den, lhs, rhs, best_num, best_den;
        lo = 0;
        while (lo < LEVELS - 1 && bin_count[lo] == 0)
            lo++;
        hi = LEVELS - 1;
        while (hi > lo && bin_count[hi] == 0)
            hi--;
        if (hi - lo <= 1)
            return lo[7:0];
        n = 0;
        s = 0;
        for (int t = lo; t <= hi; t++)
        begin
            n += bin_count[t];
            s += wide_t'(bin_count[t]) * t;
        end
        wb = 0;
        sb = 0;
        have = 1'b0;
        best = lo[7:0];
        best_num = 0;
        best_den = 1;
        for (int t = lo; t < hi; t++)
        begin
            wb += bin_count[t];
            sb += wide_t'(bin_count[t]) * t;
            p = sb * n;
            q = s * wb;
            d = (p > q) ? p - q : q - p;
            num = d * d;
            den = wb * (n - wb);
            lhs = num * best_den;
            rhs = best_num * den;
            if (!have || lhs > rhs)
            begin
                have = 1'b1;
                best = t[7:0];
                best_num = num;
                best_den = den;
            end
        end
        return best;
    endfunction

    // count one accepted pixel; returns 1 when the frame closes
    function automatic bit count_pixel(bit [7:0] pix, bit lst, output bit [7:0] thr);
        if (bin_count[pix] != 16'hffff)
            bin_count[pix]++;
        if (frame_pixels != 16'hffff)
            frame_pixels++;
        thr = 0;
        if (!lst)
            return 1'b0;
        thr = otsu_level();
        foreach (bin_count[i])
            bin_count[i] = 0;
        frame_pixels = 0;
        return 1'b1;
    endfunction

    task automatic send_pixel(bit [7:0] pix, bit lst, bit typed = 0, bit [7:0] typed_thr = 0);
        int        gap;
        bit [7:0]  thr;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                pixel_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pixel_valid <= 1'b1;
        pixel       <= pix;
        last        <= lst;
        do @(posedge clk); while (pixel_stall);
        pixels_sent++;
        if (count_pixel(pix, lst, thr))
        begin
            frames_sent++;
            if (typed && typed_thr != thr)
            begin
                $error("table threshold %0d disagrees with prediction %0d", typed_thr, thr);
                fails++;
            end
            threshold_q.push_back(thr);
        end
    endtask

    task automatic send_frame(int len, int span);
        int base;
        base = $urandom_range(0, 255 - span);
        for (int k = 0; k < len; k++)
            send_pixel(8'(base + $urandom_range(0, span)), k == len - 1);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && threshold_valid && !threshold_stall)
        begin
            results_seen++;
            if (threshold_q.size() == 0)
            begin
                $error("threshold %0d with no request pending", threshold);
                fails++;
            end
            else
            begin
                if (threshold !== threshold_q[0])
                begin
                    $error("threshold: expected %0d, actual %0d", threshold_q[0], threshold);
                    fails++;
                end
                void'(threshold_q.pop_front());
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial
    begin
        int phase;
        threshold_stall = 1'b0;
        holding = 1'b0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !holding)
            begin
                holding = 1'b1;
                threshold_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                threshold_stall <= 1'b0;
            end
            else
            begin
                phase = (phase + 1) % 400;
                if (phase < 100)
                    threshold_stall <= 1'b0;
                else
                    threshold_stall <= ($urandom_range(0, 2) == 0);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((pixel_valid && !pixel_stall) || (threshold_valid && !threshold_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("[otsu_histogram_threshold] ERROR");
            $finish;
        end
    end

    initial
    begin
        pixel_row_t rows[$];
        int wide_frames;
        rst_n = 1'b0;
        pixel = '0;
        last = 1'b0;
        pixel_valid = 1'b0;
        hold_req = 1'b0;
        fails = 0;
        burst_left = 0;
        pixels_sent = 0;
        frames_sent = 0;
        results_seen = 0;
        frame_pixels = 0;
        foreach (bin_count[i])
            bin_count[i] = 0;

        // single pixel frames, adjacent levels, equal levels, extremes
        rows.push_back('{8'd0,   1'b1, 1, 1'b1, 8'd0});
        rows.push_back('{8'd255, 1'b1, 1, 1'b1, 8'd255});
        rows.push_back('{8'd5,   1'b0, 1, 1'b0, 8'd0});
        rows.push_back('{8'd5,   1'b1, 1, 1'b1, 8'd5});
        rows.push_back('{8'd7,   1'b0, 1, 1'b0, 8'd0});
        rows.push_back('{8'd8,   1'b1, 1, 1'b1, 8'd7});
        rows.push_back('{8'd255, 1'b0, 1, 1'b0, 8'd0});
        rows.push_back('{8'd0,   1'b1, 1, 1'b1, 8'd0});
        rows.push_back('{8'd254, 1'b0, 1, 1'b0, 8'd0});
        rows.push_back('{8'd255, 1'b1, 1, 1'b1, 8'd254});
        rows.push_back('{8'd10,  1'b0, 3, 1'b0, 8'd0});
        rows.push_back('{8'd12,  1'b0, 1, 1'b0, 8'd0});
        rows.push_back('{8'd20,  1'b0, 2, 1'b0, 8'd0});
        rows.push_back('{8'd21,  1'b1, 1, 1'b0, 8'd0});
        rows.push_back('{8'd170, 1'b0, 1, 1'b0, 8'd0});
        rows.push_back('{8'd85,  1'b0, 1, 1'b0, 8'd0});
        rows.push_back('{8'd128, 1'b1, 1, 1'b0, 8'd0});
        // one heavily loaded bin against two sparse ones
        rows.push_back('{8'd10,  1'b0, 200, 1'b0, 8'd0});
        rows.push_back('{8'd100, 1'b0, 1, 1'b0, 8'd0});
        rows.push_back('{8'd200, 1'b1, 1, 1'b0, 8'd0});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[r])
            for (int k = 0; k < rows[r].reps; k++)
                send_pixel(rows[r].pix, rows[r].lst, rows[r].typed, rows[r].thr);

        // drain completely before the random part
        pixel_valid <= 1'b0;
        wait (threshold_q.size() == 0);
        @(posedge clk);

        // fill the block while the receiver holds off
        hold_req = 1'b1;
        for (int f = 0; f < 4; f++)
            send_frame($urandom_range(1, 6), $urandom_range(0, 4));

        wide_frames = 0;
        for (int base_count = pixels_sent; pixels_sent - base_count < 750; )
        begin
            if (wide_frames < 3 && $urandom_range(0, 29) == 0)
            begin
                wide_frames++;
                send_frame($urandom_range(2, 40), 255);
            end
            else
                send_frame($urandom_range(1, 40), $urandom_range(0, 7));
        end

        pixel_valid <= 1'b0;
        wait (threshold_q.size() == 0);
        repeat (100) @(posedge clk);
        $display("covered %0d pixels in %0d frames, %0d thresholds checked",
                 pixels_sent, frames_sent, results_seen);
        $display("including single-level, adjacent, full-range and heavy-bin frames");
        if (fails == 0)
            $display("[otsu_histogram_threshold] OK");
        else
            $display("[otsu_histogram_threshold] ERROR");
        $finish;
    end

endmodule
